// ===== sv/lags_pkg.sv =====
// Package for the cellular automaton grid block: sizes, cell codes, action codes,
// and the command and status structs between the controller and the datapath.
// It depends on nothing; every other file of the block but lags_ram imports it.
`default_nettype none

package lags_pkg;

    localparam int GRID_SIZE  = 32;
    localparam int IDX_W      = $clog2(GRID_SIZE);
    localparam int CELLS      = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int PAD_W      = $clog2(GRID_SIZE + 2);
    localparam int CODE_W     = 3;
    localparam int ACTION_W   = 2;
    localparam int PORT_IDX_W = 5;
    localparam int CNT_W      = 4;

    localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ALIVE = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MAX   = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // input transaction accepted this cycle
        logic step_start;  // clear the row window and all counters
        logic clr_wr;      // clearing pass: write an empty cell, advance
        logic load_rd;     // read one cell of the row being loaded, advance
        logic shift;       // move the row window down by one row
        logic cell_wr;     // write the next generation of one cell, advance
        logic res_load;    // load the output register
    } lags_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t in_act;
        logic    col_last;
        logic    row_last;
        logic    ld_pending;
        logic    ld_first;
        logic    out_busy;
    } lags_sts_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_SIZE)) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== sv/lags_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing; the grid datapath holds its cell store in it.
`default_nettype none

module lags_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/lags_ctrl.sv =====
// Controller of the grid block: sequences the clearing pass, single-cell
// actions and the row-by-row generation step. Depends on lags_pkg.
`default_nettype none

module lags_ctrl
    import lags_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire lags_sts_t sts,
    output lags_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_TAIL,
        S_SHIFT,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.col_last && sts.row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.in_act == ACT_STEP)
                    begin
                        cmd.step_start = 1'b1;
                        state_next     = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load_rd = 1'b1;
                if (sts.col_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // The last cell read of the row lands in the window this cycle.
                state_next = sts.ld_first ? S_SHIFT : S_WRITE;
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = sts.ld_pending ? S_LOAD : S_WRITE;
            end
            S_WRITE:
            begin
                cmd.cell_wr = 1'b1;
                if (sts.col_last)
                begin
                    state_next = sts.row_last ? S_FINISH : S_SHIFT;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/lags_dp.sv =====
// Datapath of the grid block: cell RAM, counters, three-row window of live
// bits, neighbor count and output register. Depends on lags_pkg and lags_ram.
`default_nettype none

module lags_dp
    import lags_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lags_cmd_t             cmd,
    output lags_sts_t                  sts,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [PORT_IDX_W-1:0] row,
    input  wire logic [PORT_IDX_W-1:0] col,
    input  wire logic [CODE_W-1:0]     cell_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [CODE_W-1:0]          cell_out,
    output logic                       step_done
);

    logic [IDX_W-1:0]     col_reg, wr_row_reg;
    logic [IDX_W:0]       ld_row_reg;
    logic                 cap_valid_reg;
    logic [IDX_W-1:0]     cap_col_reg;
    logic [GRID_SIZE-1:0] above_reg, mid_reg, below_reg;
    action_t              act_reg;
    logic                 in_range_reg;
    logic                 out_valid_reg, step_done_reg;
    logic [CODE_W-1:0]    cell_out_reg;

    logic                 col_last, row_last, advance;
    logic                 in_range;
    logic [ADDR_W-1:0]    in_addr, cnt_addr, ld_addr;
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [CODE_W-1:0]    ram_wdata, ram_rdata;

    logic [GRID_SIZE+1:0] up_pad, mid_pad, dn_pad;
    logic [PAD_W-1:0]     ci0, ci1, ci2;
    logic [CNT_W-1:0]     nbr_cnt;
    logic                 alive_next;

    assign in_range = (32'(row) < 32'(GRID_SIZE)) && (32'(col) < 32'(GRID_SIZE));
    assign in_addr  = cell_addr(IDX_W'(row), IDX_W'(col));
    assign cnt_addr = cell_addr(wr_row_reg, col_reg);
    assign ld_addr  = cell_addr(ld_row_reg[IDX_W-1:0], col_reg);

    assign col_last = (col_reg == IDX_W'(GRID_SIZE - 1));
    assign row_last = (wr_row_reg == IDX_W'(GRID_SIZE - 1));
    assign advance  = cmd.load_rd || cmd.cell_wr || cmd.clr_wr;

    // Neighbor count over the window; padding zeros stand for cells off the grid.
    assign up_pad  = {1'b0, above_reg, 1'b0};
    assign mid_pad = {1'b0, mid_reg, 1'b0};
    assign dn_pad  = {1'b0, below_reg, 1'b0};
    assign ci0     = PAD_W'(col_reg);
    assign ci1     = ci0 + PAD_W'(1);
    assign ci2     = ci0 + PAD_W'(2);

    assign nbr_cnt = CNT_W'(up_pad[ci0]) + CNT_W'(up_pad[ci1]) + CNT_W'(up_pad[ci2])
                   + CNT_W'(mid_pad[ci0]) + CNT_W'(mid_pad[ci2])
                   + CNT_W'(dn_pad[ci0]) + CNT_W'(dn_pad[ci1]) + CNT_W'(dn_pad[ci2]);

    assign alive_next = mid_pad[ci1] ? (nbr_cnt == CNT_W'(2) || nbr_cnt == CNT_W'(3))
                                     : (nbr_cnt >= CNT_W'(3));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_addr;
        ram_wdata = CODE_EMPTY;
        priority if (cmd.take)
        begin
            ram_we    = (action_t'(action) == ACT_WRITE) && in_range && (cell_in <= CODE_MAX);
            ram_waddr = in_addr;
            ram_wdata = cell_in;
        end
        else if (cmd.cell_wr)
        begin
            ram_we    = 1'b1;
            ram_wdata = alive_next ? CODE_ALIVE : CODE_EMPTY;
        end
        else if (cmd.clr_wr)
        begin
            ram_we = 1'b1;
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    assign ram_re    = cmd.take || cmd.load_rd;
    assign ram_raddr = cmd.take ? in_addr : ld_addr;

    lags_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Counters and control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            wr_row_reg    <= '0;
            ld_row_reg    <= '0;
            cap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_valid_reg <= cmd.load_rd;
            if (cmd.step_start)
            begin
                col_reg    <= '0;
                wr_row_reg <= '0;
                ld_row_reg <= '0;
            end
            else if (advance)
            begin
                col_reg <= col_last ? '0 : col_reg + IDX_W'(1);
                if (col_last && (cmd.cell_wr || cmd.clr_wr))
                begin
                    wr_row_reg <= row_last ? '0 : wr_row_reg + IDX_W'(1);
                end
                if (col_last && cmd.load_rd)
                begin
                    ld_row_reg <= ld_row_reg + (IDX_W + 1)'(1);
                end
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Row window, latched action and result payload.
    always_ff @(posedge clk)
    begin
        cap_col_reg <= col_reg;
        if (cmd.take)
        begin
            act_reg      <= action_t'(action);
            in_range_reg <= in_range;
        end
        if (cmd.step_start)
        begin
            above_reg <= '0;
            mid_reg   <= '0;
            below_reg <= '0;
        end
        else if (cmd.shift)
        begin
            above_reg <= mid_reg;
            mid_reg   <= below_reg;
            below_reg <= '0;
        end
        else if (cap_valid_reg)
        begin
            below_reg[cap_col_reg] <= (ram_rdata == CODE_ALIVE);
        end
        if (cmd.res_load)
        begin
            cell_out_reg  <= (act_reg == ACT_READ && in_range_reg) ? ram_rdata : CODE_EMPTY;
            step_done_reg <= (act_reg == ACT_STEP);
        end
    end

    assign sts.in_act     = action_t'(action);
    assign sts.col_last   = col_last;
    assign sts.row_last   = row_last;
    assign sts.ld_pending = (32'(ld_row_reg) < 32'(GRID_SIZE));
    assign sts.ld_first   = (ld_row_reg == (IDX_W + 1)'(1));
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign step_done = step_done_reg;

endmodule

`default_nettype wire

// ===== sv/life_automaton_grid_step.sv =====
// Top level of the cellular automaton grid block: joins the controller and
// the datapath. Depends on lags_pkg, lags_ctrl, lags_dp and lags_ram.
//
// Usage. The input channel (in_valid, in_stall) carries one action per
// transaction: write one cell, read one cell, or advance the grid by one
// generation. The output channel (out_valid, out_stall) returns exactly one
// result transaction for every input transaction, in order: cell_out holds
// the code read back (zero for other actions) and step_done is set after a
// generation step.
// Throughput. A write, read or unused action loads its result into the output
// register in the finish state, and the next transaction can be accepted
// once the block is back in idle. In a generation step every cell is read
// once and written once, one cell a cycle, and row loads and row writes
// take turns. One at a time: in_stall stays high until the result of the
// current transaction is loaded.
// Reset. After reset the block runs a clearing pass that writes every cell
// empty; in_stall stays high meanwhile.
// Stalls. A result waits in the output register while out_stall is high;
// a new transaction can still be accepted, and its own result waits until
// the register is taken.
`default_nettype none

module life_automaton_grid_step
    import lags_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [PORT_IDX_W-1:0] row,
    input  wire logic [PORT_IDX_W-1:0] col,
    input  wire logic [CODE_W-1:0]     cell_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [CODE_W-1:0]          cell_out,
    output logic                       step_done
);

    lags_cmd_t cmd;
    lags_sts_t sts;

    // The controller only sequences; all storage and arithmetic sit in the datapath.
    lags_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lags_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (action),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_out  (cell_out),
        .step_done (step_done)
    );

endmodule

`default_nettype wire

// ===== sv/lags_checker.sv =====
// Port-level checker for the cellular automaton grid block, bound to the top
// level. Depends on lags_pkg and on the top level's port names.
`default_nettype none

module lags_checker
    import lags_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic [ACTION_W-1:0]   action,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [CODE_W-1:0]     cell_out,
    input wire logic                  step_done
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_out) && $stable(step_done))
        else $error("stalled result changed");

    // A step result never carries a cell code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_done |-> cell_out == CODE_EMPTY)
        else $error("step result with nonzero cell code");

    // Only legal cell codes come back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cell_out <= CODE_MAX)
        else $error("illegal cell code returned");

    // A generation step keeps the input side busy after it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_STEP |=> in_stall ##1 in_stall)
        else $error("input accepted during a generation step");

endmodule

bind life_automaton_grid_step lags_checker u_lags_checker (.*);

`default_nettype wire

// ===== tb/sv/life_grid_monitor.sv =====
// Monitor for the cellular automaton grid block: it predicts every result from its own
// copy of the grid and compares it with what the output channel delivers.
// Depends on lags_pkg for the sizes, the cell codes and the action codes.
`default_nettype none

module life_grid_monitor
    import lags_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [PORT_IDX_W-1:0] row,
    input  wire logic [PORT_IDX_W-1:0] col,
    input  wire logic [CODE_W-1:0]     cell_in,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [CODE_W-1:0]     cell_out,
    input  wire logic                  step_done,
    output int                         errors,
    output int                         pending
);

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              done;
    } grid_result_t;

    grid_result_t      results_due[$];
    logic [CODE_W-1:0] grid_model [CELLS];
    bit                next_live  [CELLS];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Cells outside the grid count as dead.
    function automatic int live_at(input int r, input int c);
        if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE)
            return 0;
        return (grid_model[r * GRID_SIZE + c] == CODE_ALIVE) ? 1 : 0;
    endfunction

    // Every cell is judged from the old grid before any cell is replaced.
    task automatic advance_generation();
        int n;
        for (int r = 0; r < GRID_SIZE; r++)
        begin
            for (int c = 0; c < GRID_SIZE; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            n += live_at(r + dr, c + dc);
                if (grid_model[r * GRID_SIZE + c] == CODE_ALIVE)
                    next_live[r * GRID_SIZE + c] = (n == 2 || n == 3);
                else
                    next_live[r * GRID_SIZE + c] = (n >= 3);
            end
        end
        for (int i = 0; i < CELLS; i++)
            grid_model[i] = next_live[i] ? CODE_ALIVE : CODE_EMPTY;
    endtask

    task automatic predict_result(input action_t act, input logic [PORT_IDX_W-1:0] r,
                                  input logic [PORT_IDX_W-1:0] c,
                                  input logic [CODE_W-1:0] code,
                                  output grid_result_t res);
        bit in_range;
        in_range = (int'(r) < GRID_SIZE) && (int'(c) < GRID_SIZE);
        res.code = CODE_EMPTY;
        res.done = 1'b0;
        case (act)
            ACT_WRITE:
                if (in_range && code <= CODE_MAX)
                    grid_model[int'(r) * GRID_SIZE + int'(c)] = code;
            ACT_READ:
                if (in_range)
                    res.code = grid_model[int'(r) * GRID_SIZE + int'(c)];
            ACT_STEP:
            begin
                advance_generation();
                res.done = 1'b1;
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        grid_result_t fresh;
        if (!rst_n)
        begin
            results_due.delete();
            for (int i = 0; i < CELLS; i++)
                grid_model[i] = CODE_EMPTY;
            pending = 0;
        end
        else
        begin
            // The result taken here always belongs to an earlier transaction,
            // so it is matched before this edge's input is predicted.
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                    report($sformatf("result with nothing expected: cell_out %0d step_done %0b",
                                     cell_out, step_done));
                else
                begin
                    want = results_due.pop_front();
                    if (cell_out !== want.code)
                        report($sformatf("cell_out %0d, expected %0d", cell_out, want.code));
                    if (step_done !== want.done)
                        report($sformatf("step_done %0b, expected %0b", step_done, want.done));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_result(action_t'(action), row, col, cell_in, fresh);
                results_due.insert(results_due.size(), fresh);
            end
            pending = results_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_life_automaton_grid_step.sv =====
// Top of the testbench for the cellular automaton grid block: clock, reset, stimulus
// and verdict. Depends on lags_pkg, life_automaton_grid_step and life_grid_monitor.
`default_nettype none

module tb_life_automaton_grid_step
    import lags_pkg::*;
();

    // The limit is several times the length of a generation step and of the
    // clearing pass after reset.
    localparam int QUIET_LIMIT  = 12000;
    localparam int PHASE_QUOTA  = 60;
    localparam int SETTLE       = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [ACTION_W-1:0]   action    = ACT_NOP;
    logic [PORT_IDX_W-1:0] row       = '0;
    logic [PORT_IDX_W-1:0] col       = '0;
    logic [CODE_W-1:0]     cell_in   = '0;
    logic                  out_stall = 1'b0;
    wire logic             in_stall;
    wire logic             out_valid;
    wire logic [CODE_W-1:0] cell_out;
    wire logic             step_done;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int counted        = 0;

    always #10 clk = ~clk;

    life_automaton_grid_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_out  (cell_out),
        .step_done (step_done)
    );

    life_grid_monitor grid_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_out  (cell_out),
        .step_done (step_done),
        .errors    (mismatches),
        .pending   (outstanding)
    );

    // The receiver stalls at random with the current phase's rate. A rate of
    // zero gives stretches where every result is taken at once.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: any cycle in which neither channel completes a transaction
    // counts toward the limit; a transaction on either side clears it.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one transaction and returns at the edge where it is accepted.
    // Idle cycles come first, so valid is never dropped while a payload
    // waits, and back-to-back transactions keep valid high without a glitch.
    task automatic send(input action_t act, input logic [PORT_IDX_W-1:0] r,
                        input logic [PORT_IDX_W-1:0] c, input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        row      <= r;
        col      <= c;
        cell_in  <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Unused actions and writes of bad codes leave the grid alone, so they
        // do not count toward the quota of a phase.
        if (!(act == ACT_NOP || (act == ACT_WRITE && code > CODE_MAX)))
            counted++;
    endtask

    // Window origins lean toward the borders so that the edge rule is hit often.
    function automatic int pick_origin();
        if ($urandom_range(99) < 30)
            return $urandom_range(1) ? 0 : GRID_SIZE - 4;
        return $urandom_range(GRID_SIZE - 4);
    endfunction

    // Most bursts draw a small pattern inside a 4 by 4 window, sometimes
    // advance the grid, and read the window back; the rest is noise over
    // every field value, unused action and bad codes included.
    task automatic run_random(input int quota);
        int                r0;
        int                c0;
        logic [CODE_W-1:0] code;
        counted = 0;
        while (counted < quota)
        begin
            if ($urandom_range(99) < 70)
            begin
                r0 = pick_origin();
                c0 = pick_origin();
                repeat ($urandom_range(10, 3))
                begin
                    code = ($urandom_range(99) < 75) ? CODE_ALIVE
                                                     : CODE_W'($urandom_range(CODE_MAX));
                    send(ACT_WRITE, PORT_IDX_W'(r0 + $urandom_range(3)),
                         PORT_IDX_W'(c0 + $urandom_range(3)), code);
                end
                if ($urandom_range(99) < 40)
                    send(ACT_STEP, PORT_IDX_W'($urandom), PORT_IDX_W'($urandom),
                         CODE_W'($urandom));
                repeat ($urandom_range(5, 2))
                    send(ACT_READ, PORT_IDX_W'(r0 + $urandom_range(3)),
                         PORT_IDX_W'(c0 + $urandom_range(3)), CODE_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send(action_t'(ACTION_W'($urandom_range(3))), PORT_IDX_W'($urandom),
                         PORT_IDX_W'($urandom), CODE_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling. A blinker lies along the top edge so that
        // the missing row above must count as dead; a code 3 cell under it and
        // a code 4 cell in the far corner each see three live neighbors and
        // must be reborn as live cells.
        send(ACT_WRITE, 5'd0, 5'd0, CODE_ALIVE);
        send(ACT_WRITE, 5'd0, 5'd1, CODE_ALIVE);
        send(ACT_WRITE, 5'd0, 5'd2, CODE_ALIVE);
        send(ACT_WRITE, 5'd1, 5'd1, 3'd3);
        send(ACT_WRITE, 5'd31, 5'd31, CODE_MAX);
        send(ACT_WRITE, 5'd31, 5'd30, CODE_ALIVE);
        send(ACT_WRITE, 5'd30, 5'd31, CODE_ALIVE);
        send(ACT_WRITE, 5'd30, 5'd30, CODE_ALIVE);
        // Codes above the largest kind must leave the cell as it was.
        send(ACT_WRITE, 5'd15, 5'd15, 3'd7);
        send(ACT_READ, 5'd15, 5'd15, 3'd0);
        send(ACT_WRITE, 5'd20, 5'd20, 3'd2);
        send(ACT_WRITE, 5'd20, 5'd20, 3'd5);
        send(ACT_READ, 5'd20, 5'd20, 3'd7);
        // The unused action returns an empty result and changes nothing.
        send(ACT_NOP, 5'd31, 5'd31, 3'd7);
        send(ACT_READ, 5'd0, 5'd1, 3'd0);
        send(ACT_READ, 5'd31, 5'd31, 3'd0);
        send(ACT_STEP, 5'd0, 5'd0, 3'd0);
        send(ACT_READ, 5'd0, 5'd0, 3'd0);
        send(ACT_READ, 5'd0, 5'd1, 3'd0);
        send(ACT_READ, 5'd1, 5'd1, 3'd0);
        send(ACT_READ, 5'd31, 5'd31, 3'd0);
        send(ACT_READ, 5'd20, 5'd20, 3'd0);
        send(ACT_STEP, 5'd31, 5'd31, 3'd7);
        send(ACT_READ, 5'd0, 5'd1, 3'd0);
        send(ACT_READ, 5'd1, 5'd1, 3'd0);

        // Random part over four idling phases.
        run_random(PHASE_QUOTA);
        send_idle_pct = 51;
        run_random(PHASE_QUOTA);
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        run_random(PHASE_QUOTA);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        run_random(PHASE_QUOTA);

        // Drain: the watchdog bounds this wait if a result never comes.
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
